[hw/rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/srp_pkg.sv]
// -----------------------------------------------------------------------------
// srp_pkg
// Types, constants and fixed-point helpers shared by the run-probability block.
// -----------------------------------------------------------------------------
package srp_pkg;

	localparam int          PROB_W      = 17;
	localparam int          COUNT_W     = 32;
	localparam int          STREAK_W    = 10;
	localparam int          PADDR_W     = 3;
	localparam int          PDATA_W     = 32;

	localparam logic [PROB_W-1:0]  Q_ONE       = 17'd65536;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;
	localparam logic [STREAK_W-1:0] STREAK_RST = 10'd1;
	localparam logic [PROB_W-1:0]  WIN_P_RST   = 17'd64881;

	// Register index, taken from paddr[2].
	localparam logic REG_STREAK = 1'b0;
	localparam logic REG_WIN_P  = 1'b1;

	// Configuration as the datapath sees it, already clamped to legal range.
	typedef struct packed {
		logic [STREAK_W-1:0] streak;
		logic [PROB_W-1:0]   prob;
	} cfg_t;

	// Sequence state carried from one word to the next.
	typedef struct packed {
		logic [PROB_W-1:0]  last;
		logic [PROB_W-1:0]  pacc;
		logic [PROB_W-1:0]  coeff;
		logic [COUNT_W-1:0] trial;
		logic               held;
	} seq_state_t;

	localparam seq_state_t SEQ_START = '{
		last:  '0,
		pacc:  Q_ONE,
		coeff: '0,
		trial: '0,
		held:  1'b0
	};

	// Q1.16 product, truncated. Operands never exceed one, so 17 bits hold it.
	function automatic logic [PROB_W-1:0] qmul(input logic [PROB_W-1:0] a,
			input logic [PROB_W-1:0] b);
		logic [2*PROB_W-1:0] prod;
		prod = {{PROB_W{1'b0}}, a} * {{PROB_W{1'b0}}, b};
		return prod[PROB_W+15:16];
	endfunction

endpackage

[hw/rtl/srp_in_if.sv]
// -----------------------------------------------------------------------------
// srp_in_if
// Input channel: one restart flag per word, valid/ready handshake.
// -----------------------------------------------------------------------------
interface srp_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

[hw/rtl/srp_out_if.sv]
// -----------------------------------------------------------------------------
// srp_out_if
// Result channel: run probability and trial count, valid/ready handshake.
// -----------------------------------------------------------------------------
interface srp_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] run_prob;
	logic [31:0] trial_count;

	modport source (output valid, output run_prob, output trial_count, input ready);
	modport sink   (input valid, input run_prob, input trial_count, output ready);
endinterface

[hw/rtl/success_run_probability_top.sv]
// -----------------------------------------------------------------------------
// success_run_probability_top
// Streams the probability of a run of K wins within x Bernoulli trials.
// -----------------------------------------------------------------------------
// Each accepted word on the trials channel either restarts the sequence at
// trial count zero or advances it by one, and yields exactly one result word
// carrying W[x] in unsigned Q1.16 (65536 is 1.0) and the trial count x. The
// block takes one word per clock while results are taken: a word is captured
// in an input register, the recursion runs in a single combinational step
// (17x17 multiplies, an add and a saturating compare) and lands in the result
// register when the input stage advances, from where the result can be taken.
// The result register decouples the two sides, so a new word is accepted
// while an earlier result waits to be taken. The rate is set by the history
// memory, which serves one read and one write per clock: the read of W[x-K-1]
// is issued at the edge the word is accepted, so it is ready when the word
// computes. The memory holds HISTORY_DEPTH results and needs no clearing
// after reset, because only entries written earlier in the current sequence
// are ever read. Run length K is clamped to 1 .. min(HISTORY_DEPTH-1, 1023)
// and win probability to 1.0. Registers (APB, 32-bit data):
// run length at byte address 0, win probability at byte address 4; write
// them only while no word is in flight. After trial count 2^32-1 the block
// repeats that last result until a restart.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module success_run_probability_top
	import srp_pkg::*;
#(
	parameter int HISTORY_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	srp_in_if.sink             trials,
	srp_out_if.source          results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int AW = PW + 2;
	localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_DEPTH - 1);

	cfg_t               cfg;

	// Input register stage.
	logic               valid_s1;
	logic               restart_s1;
	logic               adv_s1;

	// Sequence state and ring write pointer (position of the next trial).
	seq_state_t         state_q;
	seq_state_t         state_nxt;
	logic [PW-1:0]      ptr_q;
	logic [PW-1:0]      cur_ptr;

	// Result register.
	logic               res_valid_q;
	logic [PROB_W-1:0]  res_prob_q;
	logic [COUNT_W-1:0] res_trial_q;

	logic [PROB_W-1:0]  step_prob;
	logic [COUNT_W-1:0] step_trial;
	logic               ring_we;
	logic [PROB_W-1:0]  back;
	logic               in_fire;

	logic [AW-1:0]      rd_base;
	logic [AW-1:0]      rd_off;
	logic [AW-1:0]      rd_diff;
	logic [PW-1:0]      rd_addr;

	assign pready = 1'b1;

	srp_cfg #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The stage advances whenever the result register is free or being drained.
	assign adv_s1        = valid_s1 && (!res_valid_q || results.ready);
	assign trials.ready  = !valid_s1 || adv_s1;
	assign in_fire       = trials.valid && trials.ready;

	assign cur_ptr = restart_s1 ? '0 : ptr_q;

	// The incoming word's trial count is one past the word now computing, or
	// the stored next trial when nothing computes. It needs W[x-K-1], so the
	// read sits K (or K+1) places behind that pointer, modulo the ring depth.
	always_comb begin
		if (adv_s1) begin
			rd_base = AW'(cur_ptr);
			rd_off  = AW'(cfg.streak);
		end else begin
			rd_base = AW'(ptr_q);
			rd_off  = AW'(cfg.streak) + AW'(1);
		end
		rd_diff = rd_base - rd_off;
		if (rd_diff[AW-1])
			rd_diff = rd_diff + AW'(HISTORY_DEPTH);
		rd_addr = rd_diff[PW-1:0];
	end

	srp_ring #(
		.DEPTH (HISTORY_DEPTH),
		.PW    (PW)
	) u_ring (
		.clk     (clk),
		.wr_en   (adv_s1 && ring_we),
		.wr_addr (cur_ptr),
		.wr_data (step_prob),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (back)
	);

	srp_step u_step (
		.restart   (restart_s1),
		.state     (state_q),
		.cfg       (cfg),
		.back      (back),
		.state_nxt (state_nxt),
		.prob      (step_prob),
		.trial     (step_trial),
		.ring_we   (ring_we)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (trials.ready) begin
			valid_s1 <= trials.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			restart_s1 <= trials.restart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_START;
			ptr_q   <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
			if (ring_we)
				ptr_q <= (cur_ptr == PTR_LAST) ? '0 : cur_ptr + PW'(1);
			else
				ptr_q <= cur_ptr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_prob_q  <= step_prob;
			res_trial_q <= step_trial;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.run_prob    = res_prob_q;
	assign results.trial_count = res_trial_q;

	// A result never exceeds one.
	`ASSERT_ALWAYS(a_prob_range, !res_valid_q || (res_prob_q <= Q_ONE), "result above one")
	// A word leaving the input stage is in the result register next cycle.
	`ASSERT_NEXT(a_adv_result, adv_s1, res_valid_q, "advanced word lost")
	// With the result register empty the block must take input.
	`ASSERT_ALWAYS(a_ready_empty, res_valid_q || trials.ready, "stalled with empty output")
	// The ring pointer stays inside the memory.
	`ASSERT_ALWAYS(a_ptr_range, ptr_q <= PTR_LAST, "ring pointer out of range")

endmodule

[hw/rtl/srp_cfg.sv]
// -----------------------------------------------------------------------------
// srp_cfg
// APB register file for run length and win probability, with range clamping.
// -----------------------------------------------------------------------------
module srp_cfg
	import srp_pkg::*;
#(
	parameter int HISTORY_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	localparam int KMAX = (HISTORY_DEPTH - 1 < 1023) ? HISTORY_DEPTH - 1 : 1023;
	localparam logic [STREAK_W-1:0] KMAX_V = STREAK_W'(KMAX);

	logic [STREAK_W-1:0] streak_q;
	logic [PROB_W-1:0]   win_p_q;
	logic                wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streak_q <= STREAK_RST;
			win_p_q  <= WIN_P_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_STREAK: streak_q <= pwdata[STREAK_W-1:0];
				REG_WIN_P:  win_p_q  <= pwdata[PROB_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_STREAK: prdata = PDATA_W'(streak_q);
			REG_WIN_P:  prdata = PDATA_W'(win_p_q);
			default:    prdata = '0;
		endcase
	end

	// A zero run length acts as one; lengths beyond KMAX (ring depth less one, at most 1023) act as KMAX.
	always_comb begin
		if (streak_q == '0)
			cfg.streak = STREAK_W'(1);
		else if (streak_q > KMAX_V)
			cfg.streak = KMAX_V;
		else
			cfg.streak = streak_q;
		cfg.prob = (win_p_q > Q_ONE) ? Q_ONE : win_p_q;
	end

endmodule

[hw/rtl/srp_ring.sv]
// -----------------------------------------------------------------------------
// srp_ring
// History memory of past results: one write port, one registered read port.
// -----------------------------------------------------------------------------
module srp_ring
	import srp_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int PW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [PW-1:0]     wr_addr,
	input  logic [PROB_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [PW-1:0]     rd_addr,
	output logic [PROB_W-1:0] rd_data
);

	logic [PROB_W-1:0] mem [DEPTH];
	logic [PROB_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/srp_step.sv]
// -----------------------------------------------------------------------------
// srp_step
// One trial of the recursion: next result and next sequence state.
// -----------------------------------------------------------------------------
module srp_step
	import srp_pkg::*;
(
	input  logic               restart,
	input  seq_state_t         state,
	input  cfg_t               cfg,
	input  logic [PROB_W-1:0]  back,
	output seq_state_t         state_nxt,
	output logic [PROB_W-1:0]  prob,
	output logic [COUNT_W-1:0] trial,
	output logic               ring_we
);

	seq_state_t         st;
	logic [PROB_W-1:0]  incr;
	logic [PROB_W:0]    sum;
	logic [COUNT_W-1:0] k_ext;

	always_comb begin
		st        = restart ? SEQ_START : state;
		state_nxt = st;
		k_ext     = COUNT_W'(cfg.streak);
		incr      = qmul(st.coeff, Q_ONE - back);
		sum       = {1'b0, st.last} + {1'b0, incr};
		prob      = '0;
		trial     = st.trial;
		ring_we   = 1'b0;
		if (st.held) begin
			// Count has saturated: repeat the last result, touch nothing.
			prob = st.last;
		end else begin
			ring_we = 1'b1;
			if (st.trial < k_ext) begin
				prob           = '0;
				state_nxt.pacc = qmul(st.pacc, cfg.prob);
			end else if (st.trial == k_ext) begin
				prob            = st.pacc;
				state_nxt.coeff = qmul(st.pacc, Q_ONE - cfg.prob);
			end else begin
				prob = (sum > {1'b0, Q_ONE}) ? Q_ONE : sum[PROB_W-1:0];
			end
			state_nxt.last = prob;
			if (st.trial == COUNT_MAX)
				state_nxt.held = 1'b1;
			else
				state_nxt.trial = st.trial + COUNT_W'(1);
		end
	end

endmodule
